FILE: rtl/core/tdr_pkg.sv
// Package for the divider timer with reload: item and result types,
// register addresses, item kind codes and reload sequence constants. No dependencies.
`timescale 1ns / 1ps

package tdr_pkg;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   localparam logic [15:0] ADDR_DIV  = 16'hFF04;
   localparam logic [15:0] ADDR_CNT  = 16'hFF05;
   localparam logic [15:0] ADDR_MOD  = 16'hFF06;
   localparam logic [15:0] ADDR_CTRL = 16'hFF07;

   localparam logic [7:0] CTRL_READ_PAD = 8'hF8;
   localparam int         CTRL_BITS     = 3;

   localparam logic [2:0] RELOAD_IRQ_AGE  = 3'd4;
   localparam logic [2:0] RELOAD_LOAD_AGE = 3'd5;
   localparam logic [2:0] RELOAD_END_AGE  = 3'd6;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] address;
      logic [7:0]  write_data;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
   } result_type;

   typedef struct packed {
      logic       reload_pending;
      logic [2:0] reload_age;
   } status_type;

endpackage

FILE: rtl/core/tdr_core.sv
// Timer state and single-item update: divider, counter, modulo, control and reload sequence.
// Depends on tdr_pkg.
`timescale 1ns / 1ps

module tdr_core #(
   parameter int DIVIDER_BITS = 16,
   parameter int TAP_BIT_0    = 9,
   parameter int TAP_BIT_1    = 3,
   parameter int TAP_BIT_2    = 5,
   parameter int TAP_BIT_3    = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  tdr_pkg::item_type   item,
   output tdr_pkg::result_type result,
   output tdr_pkg::status_type status
);

   logic [DIVIDER_BITS-1:0]       divider_ff, divider_in;
   logic [7:0]                    counter_ff, counter_in;
   logic [7:0]                    modulo_ff, modulo_in;
   logic [tdr_pkg::CTRL_BITS-1:0] control_ff, control_in;
   logic                          prev_tap_ff, prev_tap_in;
   logic                          pending_ff, pending_in;
   logic [2:0]                    age_ff, age_in;

   // Divider bits at or above DIVIDER_BITS read as zero through the extension.
   function automatic logic tap_of(input logic [15:0] div, input logic [1:0] sel);
      logic t;
      case (sel)
         2'd0:    t = div[TAP_BIT_0];
         2'd1:    t = div[TAP_BIT_1];
         2'd2:    t = div[TAP_BIT_2];
         default: t = div[TAP_BIT_3];
      endcase
      return t;
   endfunction

   always_comb begin
      logic [DIVIDER_BITS-1:0] div_next;
      logic [15:0] div_ext;
      logic [15:0] div_new_ext;
      logic        tap_now;
      logic        old_hit;
      logic [2:0]  new_ctrl;

      // Wrap at the divider width before extending.
      div_next    = divider_ff + 1'b1;
      div_ext     = 16'(divider_ff);
      div_new_ext = 16'(div_next);
      tap_now     = 1'b0;
      old_hit     = 1'b0;
      new_ctrl    = item.write_data[tdr_pkg::CTRL_BITS-1:0];

      divider_in  = divider_ff;
      counter_in  = counter_ff;
      modulo_in   = modulo_ff;
      control_in  = control_ff;
      prev_tap_in = prev_tap_ff;
      pending_in  = pending_ff;
      age_in      = age_ff;
      result      = '0;

      case (item.kind)
         tdr_pkg::KIND_TICK: begin
            divider_in = div_next;
            tap_now    = tap_of(div_new_ext, control_ff[1:0]) & control_ff[2];
            if (prev_tap_ff && !tap_now) begin
               counter_in = counter_ff + 8'd1;
               if (counter_in == 8'd0) begin
                  pending_in = 1'b1;
                  age_in     = 3'd0;
               end
            end
            prev_tap_in = tap_now;
            if (pending_in) begin
               age_in = age_in + 3'd1;
               if (age_in == tdr_pkg::RELOAD_IRQ_AGE) begin
                  result.irq = 1'b1;
               end else if (age_in == tdr_pkg::RELOAD_LOAD_AGE) begin
                  counter_in = modulo_ff;
               end else if (age_in >= tdr_pkg::RELOAD_END_AGE) begin
                  pending_in = 1'b0;
                  age_in     = 3'd0;
               end
            end
         end
         tdr_pkg::KIND_READ: begin
            unique case (item.address)
               tdr_pkg::ADDR_DIV:  result.read_data = div_ext[15:8];
               tdr_pkg::ADDR_CNT:  result.read_data = counter_ff;
               tdr_pkg::ADDR_MOD:  result.read_data = modulo_ff;
               tdr_pkg::ADDR_CTRL: result.read_data = tdr_pkg::CTRL_READ_PAD | 8'(control_ff);
               default:            result.read_data = 8'd0;
            endcase
         end
         tdr_pkg::KIND_WRITE: begin
            unique case (item.address)
               tdr_pkg::ADDR_DIV: begin
                  divider_in = '0;
               end
               tdr_pkg::ADDR_CNT: begin
                  // The write loses to the modulo load in the reload tick.
                  if (age_ff != tdr_pkg::RELOAD_LOAD_AGE) begin
                     counter_in = item.write_data;
                     pending_in = 1'b0;
                     age_in     = 3'd0;
                  end
               end
               tdr_pkg::ADDR_MOD: begin
                  modulo_in = item.write_data;
                  if (age_ff == tdr_pkg::RELOAD_LOAD_AGE) begin
                     counter_in = item.write_data;
                  end
               end
               tdr_pkg::ADDR_CTRL: begin
                  control_in = new_ctrl;
                  old_hit    = control_ff[2] & tap_of(div_ext, control_ff[1:0]);
                  // Disable or tap change while the gated tap is high counts a falling edge.
                  if (old_hit && (!new_ctrl[2] || !tap_of(div_ext, new_ctrl[1:0]))) begin
                     counter_in = counter_ff + 8'd1;
                     if (counter_in == 8'd0) begin
                        counter_in = modulo_ff;
                        result.irq = 1'b1;
                     end
                     prev_tap_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff  <= '0;
         counter_ff  <= '0;
         modulo_ff   <= '0;
         control_ff  <= '0;
         prev_tap_ff <= 1'b0;
         pending_ff  <= 1'b0;
         age_ff      <= '0;
      end else if (step_en) begin
         divider_ff  <= divider_in;
         counter_ff  <= counter_in;
         modulo_ff   <= modulo_in;
         control_ff  <= control_in;
         prev_tap_ff <= prev_tap_in;
         pending_ff  <= pending_in;
         age_ff      <= age_in;
      end
   end

   assign status.reload_pending = pending_ff;
   assign status.reload_age     = age_ff;

endmodule

FILE: rtl/core/divider_timer_with_reload_top.sv
// Top level of the divider timer with reload: input register, result register, handshakes.
// Depends on tdr_pkg and tdr_core.
`timescale 1ns / 1ps

// Usage:
//   Each req item is a tick (tuser 0), a bus read (1) or a bus write (2) to the
//   timer registers at 0xFF04..0xFF07; tuser 3 is a no-op. Every item returns
//   exactly one rsp item holding the read byte (zero unless a timer read) and
//   the irq flag, raised when the timer interrupt fires during that item.
//   An accepted item is held in the input register, is executed against the
//   timer state once the result register is free, and shows on rsp from then.
//   Throughput: one item per cycle while rsp is not stalled.
//   The input register and the result register decouple the two sides: a
//   stalled rsp holds its item, and req_tready drops once the input register
//   also holds an item.
//   Reset (synchronous, active high) clears divider, counter, modulo, control
//   and any pending reload, and empties both registers; no clearing pass.

module divider_timer_with_reload_top #(
   parameter int DIVIDER_BITS = 16,
   parameter int TAP_BIT_0    = 9,
   parameter int TAP_BIT_1    = 3,
   parameter int TAP_BIT_2    = 5,
   parameter int TAP_BIT_3    = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [15:0] address, [23:16] write_data
   input  logic [1:0]  req_tuser,  // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // [7:0] read_data, [8] irq, [15:9] zero
);

   logic                in_valid_ff;
   tdr_pkg::item_type   in_item_ff;
   logic                rsp_valid_ff;
   tdr_pkg::result_type rsp_data_ff;
   tdr_pkg::result_type core_result;
   tdr_pkg::status_type core_status;
   tdr_pkg::item_type   req_item;
   logic                advance;
   logic                step_en;

   assign req_item.kind       = req_tuser;
   assign req_item.address    = req_tdata[15:0];
   assign req_item.write_data = req_tdata[23:16];

   // Result slot frees when empty or taken this cycle.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   tdr_core #(
      .DIVIDER_BITS (DIVIDER_BITS),
      .TAP_BIT_0    (TAP_BIT_0),
      .TAP_BIT_1    (TAP_BIT_1),
      .TAP_BIT_2    (TAP_BIT_2),
      .TAP_BIT_3    (TAP_BIT_3)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .result  (core_result),
      .status  (core_status)
   );

   // Input register: load when the held item moves on or the slot is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
   end

   // Result register: hold while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff.irq, rsp_data_ff.read_data};

`ifndef SYNTHESIS
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("req_tready low without both registers full and rsp stalled");

   a_read_no_irq: assert property (@(posedge clock) disable iff (reset)
      (step_en && in_item_ff.kind == tdr_pkg::KIND_READ) |=> !rsp_tdata[8])
      else $error("irq raised by a bus read");

   a_idle_age_zero: assert property (@(posedge clock) disable iff (reset)
      !core_status.reload_pending |-> core_status.reload_age == 3'd0)
      else $error("reload age nonzero with no reload pending");

   a_pending_age_range: assert property (@(posedge clock) disable iff (reset)
      core_status.reload_pending |->
         (core_status.reload_age != 3'd0 && core_status.reload_age < tdr_pkg::RELOAD_END_AGE))
      else $error("reload age out of range while pending");
`endif

endmodule
